/* hdl/gpl_pkg.sv */
package gpl_pkg;

  localparam int IDX_W    = 11;
  localparam int COLOR_W  = 24;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int COUNT_W  = 3;
  localparam int STEPS_W  = 8;
  localparam int CFG_W    = 24;
  localparam int REG_ADDR_W = 3;

  // percent = pos * 100 / steps, always below 100
  localparam int PCT_W    = 7;
  localparam int PROD_W   = STEPS_W + PCT_W;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // x / 100 == (x * 5243) >> 19 for every x below 43690
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_PROD_W = PROD_W + RECIP_W;

  // register indexes
  localparam logic [REG_ADDR_W-1:0] REG_NUM_COLORS      = 3'd0;
  localparam logic [REG_ADDR_W-1:0] REG_STEPS_PER_COLOR = 3'd1;
  localparam int KEY_BASE = 2;
  localparam int KEY_SLOTS = 6;

  localparam logic [COUNT_W-1:0] NUM_COLORS_RESET = 3'd3;
  localparam logic [STEPS_W-1:0] STEPS_RESET      = 8'd20;

  typedef logic [COLOR_W-1:0] color_t;
  typedef color_t key_reset_t [KEY_SLOTS];
  localparam key_reset_t KEY_RESET = '{24'hFF0000, 24'hFFFF00, 24'h0000FF,
                                       24'h000000, 24'h000000, 24'h000000};

endpackage

/* hdl/gpl_index_if.sv */
interface gpl_index_if;
  logic                      valid;
  logic                      ready;
  logic [gpl_pkg::IDX_W-1:0] palette_index;

  modport source (output valid, output palette_index, input ready);
  modport sink   (input valid, input palette_index, output ready);
endinterface

/* hdl/gpl_color_if.sv */
interface gpl_color_if;
  logic                        valid;
  logic                        ready;
  logic [gpl_pkg::COLOR_W-1:0] palette_color;

  modport source (output valid, output palette_color, input ready);
  modport sink   (input valid, input palette_color, output ready);
endinterface

/* hdl/gradient_palette_lookup.sv */
// Cyclic RGB gradient palette lookup.
// index_chan carries a request (palette_index); color_chan returns one
// palette_color per request, in order. Both use valid/ready; a request is
// taken on a clock edge where valid and ready are both high.
// Configuration goes through cfg_we/cfg_index/cfg_data (index 0 colour count,
// 1 steps per colour, 2..7 key colours) and must only be written while no
// request is in flight.
// A request passes through 11 bit-serial stages that divide the
// index by the step count (the segment modulo the colour count is reduced in
// the same stages), one stage scales the position by 100, 7 stages divide it
// to the percent, then colour select, channel multiply, reciprocal multiply
// for /100 and the output register.
// Throughput is one request per cycle. The whole pipeline advances on one
// enable; when the receiver stalls a full output register, every stage holds
// and index_chan.ready drops in the same cycle.
// Reset loads the default gradient (red, yellow, blue over 20 steps) and
// empties the pipeline.
module gradient_palette_lookup #(
  parameter int MAX_COLORS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gpl_pkg::REG_ADDR_W-1:0]      cfg_index,
  input  logic [gpl_pkg::CFG_W-1:0]           cfg_data,
  gpl_index_if.sink                           index_chan,
  gpl_color_if.source                         color_chan
);

  localparam int NA = gpl_pkg::IDX_W;
  localparam int NB = gpl_pkg::PCT_W;
  localparam int CW = gpl_pkg::CH_W;
  localparam int SW = gpl_pkg::STEPS_W;
  localparam int KW = gpl_pkg::COUNT_W;
  localparam int PW = gpl_pkg::PROD_W;

  // ---------------- configuration registers ----------------
  logic [KW-1:0]            num_colors;
  logic [SW-1:0]            steps_per_color;
  gpl_pkg::color_t          key_color [MAX_COLORS];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors      <= gpl_pkg::NUM_COLORS_RESET;
      steps_per_color <= gpl_pkg::STEPS_RESET;
      for (int k = 0; k < MAX_COLORS; k++) key_color[k] <= gpl_pkg::KEY_RESET[k];
    end else if (cfg_we) begin
      if (cfg_index == gpl_pkg::REG_NUM_COLORS) num_colors <= cfg_data[KW-1:0];
      if (cfg_index == gpl_pkg::REG_STEPS_PER_COLOR) steps_per_color <= cfg_data[SW-1:0];
      for (int k = 0; k < MAX_COLORS; k++) begin
        if (int'(cfg_index) == gpl_pkg::KEY_BASE + k) key_color[k] <= cfg_data;
      end
    end
  end

  logic [KW-1:0] count_eff;
  logic [SW-1:0] steps_eff;

  always_comb begin
    priority if (num_colors == '0) count_eff = KW'(1);
    else if (num_colors > KW'(MAX_COLORS)) count_eff = KW'(MAX_COLORS);
    else count_eff = num_colors;
    steps_eff = (steps_per_color == '0) ? SW'(1) : steps_per_color;
  end

  // ---------------- pipeline control ----------------
  logic advance;
  logic f_v;

  assign advance = !f_v || color_chan.ready;
  assign index_chan.ready = advance;

  // ---------------- index / steps, segment mod count ----------------
  logic [NA-1:0] a_v;
  logic [NA-1:0] a_idx      [NA];
  logic [SW-1:0] a_rem      [NA];
  logic [KW-1:0] a_seg      [NA];
  logic [NA-1:0] a_idx_in   [NA];
  logic [SW-1:0] a_rem_in   [NA];
  logic [KW-1:0] a_seg_in   [NA];
  logic [NA-1:0] a_idx_next [NA];
  logic [SW-1:0] a_rem_next [NA];
  logic [KW-1:0] a_seg_next [NA];

  always_comb begin
    a_idx_in[0] = index_chan.palette_index;
    a_rem_in[0] = '0;
    a_seg_in[0] = '0;
    for (int j = 1; j < NA; j++) begin
      a_idx_in[j] = a_idx[j-1];
      a_rem_in[j] = a_rem[j-1];
      a_seg_in[j] = a_seg[j-1];
    end
  end

  always_comb begin
    logic [SW:0]   t;
    logic          qbit;
    logic [KW:0]   s2;
    for (int j = 0; j < NA; j++) begin
      t    = {a_rem_in[j], a_idx_in[j][NA-1]};
      qbit = (t >= {1'b0, steps_eff});
      a_rem_next[j] = qbit ? SW'(t - {1'b0, steps_eff}) : t[SW-1:0];
      a_idx_next[j] = {a_idx_in[j][NA-2:0], 1'b0};
      // quotient bits arrive MSB first: fold them into the running modulo
      s2 = {a_seg_in[j], qbit};
      a_seg_next[j] = (s2 >= {1'b0, count_eff}) ? KW'(s2 - {1'b0, count_eff})
                                                : s2[KW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < NA; j++) begin
        a_idx[j] <= a_idx_next[j];
        a_rem[j] <= a_rem_next[j];
        a_seg[j] <= a_seg_next[j];
      end
    end
  end

  // ---------------- position * 100 ----------------
  logic          m_v;
  logic [PW-1:0] m_prod;
  logic [KW-1:0] m_seg;

  always_ff @(posedge clk) begin
    if (advance) begin
      m_prod <= PW'(a_rem[NA-1]) * PW'(gpl_pkg::PCT_SCALE);
      m_seg  <= a_seg[NA-1];
    end
  end

  // ---------------- (position * 100) / steps ----------------
  // quotient stays below 128, so the top bits already sit below the divisor
  logic [NB-1:0] b_v;
  logic [SW-1:0] b_rem      [NB];
  logic [NB-1:0] b_low      [NB];
  logic [NB-1:0] b_q        [NB];
  logic [KW-1:0] b_seg      [NB];
  logic [SW-1:0] b_rem_in   [NB];
  logic [NB-1:0] b_low_in   [NB];
  logic [NB-1:0] b_q_in     [NB];
  logic [KW-1:0] b_seg_in   [NB];
  logic [SW-1:0] b_rem_next [NB];
  logic [NB-1:0] b_low_next [NB];
  logic [NB-1:0] b_q_next   [NB];

  always_comb begin
    b_rem_in[0] = m_prod[PW-1 -: SW];
    b_low_in[0] = m_prod[NB-1:0];
    b_q_in[0]   = '0;
    b_seg_in[0] = m_seg;
    for (int j = 1; j < NB; j++) begin
      b_rem_in[j] = b_rem[j-1];
      b_low_in[j] = b_low[j-1];
      b_q_in[j]   = b_q[j-1];
      b_seg_in[j] = b_seg[j-1];
    end
  end

  always_comb begin
    logic [SW:0] t;
    logic        qbit;
    for (int j = 0; j < NB; j++) begin
      t    = {b_rem_in[j], b_low_in[j][NB-1]};
      qbit = (t >= {1'b0, steps_eff});
      b_rem_next[j] = qbit ? SW'(t - {1'b0, steps_eff}) : t[SW-1:0];
      b_low_next[j] = {b_low_in[j][NB-2:0], 1'b0};
      b_q_next[j]   = {b_q_in[j][NB-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < NB; j++) begin
        b_rem[j] <= b_rem_next[j];
        b_low[j] <= b_low_next[j];
        b_q[j]   <= b_q_next[j];
        b_seg[j] <= b_seg_in[j];
      end
    end
  end

  // ---------------- key colour select ----------------
  logic            c_v;
  gpl_pkg::color_t c_start;
  gpl_pkg::color_t c_end;
  logic [NB-1:0]   c_pct;
  gpl_pkg::color_t sel_start;
  gpl_pkg::color_t sel_end;
  logic [KW-1:0]   seg_last;
  logic [KW-1:0]   seg_next;

  always_comb begin
    seg_last = b_seg[NB-1];
    seg_next = (KW'(seg_last + KW'(1)) == count_eff) ? '0 : KW'(seg_last + KW'(1));
    sel_start = '0;
    sel_end   = '0;
    for (int k = 0; k < MAX_COLORS; k++) begin
      if (seg_last == KW'(k)) sel_start = key_color[k];
      if (seg_next == KW'(k)) sel_end   = key_color[k];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_start <= sel_start;
      c_end   <= sel_end;
      c_pct   <= b_q[NB-1];
    end
  end

  // ---------------- |delta| * percent ----------------
  logic          d_v;
  logic [PW-1:0] d_prod  [gpl_pkg::NUM_CH];
  logic          d_neg   [gpl_pkg::NUM_CH];
  logic [CW-1:0] d_start [gpl_pkg::NUM_CH];

  always_ff @(posedge clk) begin
    logic [CW:0]   delta;
    logic [CW-1:0] mag;
    if (advance) begin
      for (int c = 0; c < gpl_pkg::NUM_CH; c++) begin
        delta = {1'b0, c_end[c*CW +: CW]} - {1'b0, c_start[c*CW +: CW]};
        mag   = delta[CW] ? CW'(-delta) : delta[CW-1:0];
        d_prod[c]  <= PW'(mag) * PW'(c_pct);
        d_neg[c]   <= delta[CW];
        d_start[c] <= c_start[c*CW +: CW];
      end
    end
  end

  // ---------------- divide by 100 (reciprocal) ----------------
  logic          e_v;
  logic [CW-1:0] e_q     [gpl_pkg::NUM_CH];
  logic          e_neg   [gpl_pkg::NUM_CH];
  logic [CW-1:0] e_start [gpl_pkg::NUM_CH];

  always_ff @(posedge clk) begin
    logic [gpl_pkg::RECIP_PROD_W-1:0] full;
    if (advance) begin
      for (int c = 0; c < gpl_pkg::NUM_CH; c++) begin
        full = gpl_pkg::RECIP_PROD_W'(d_prod[c]) *
               gpl_pkg::RECIP_PROD_W'(gpl_pkg::RECIP);
        e_q[c]     <= full[gpl_pkg::RECIP_SHIFT +: CW];
        e_neg[c]   <= d_neg[c];
        e_start[c] <= d_start[c];
      end
    end
  end

  // ---------------- output register ----------------
  gpl_pkg::color_t f_color;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < gpl_pkg::NUM_CH; c++) begin
        // truncation toward zero: the magnitude was divided, sign goes back on
        f_color[c*CW +: CW] <= e_neg[c] ? CW'(e_start[c] - e_q[c])
                                        : CW'(e_start[c] + e_q[c]);
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= '0;
      m_v <= 1'b0;
      b_v <= '0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
    end else if (advance) begin
      a_v <= {a_v[NA-2:0], index_chan.valid};
      m_v <= a_v[NA-1];
      b_v <= {b_v[NB-2:0], m_v};
      c_v <= b_v[NB-1];
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
    end
  end

  assign color_chan.valid         = f_v;
  assign color_chan.palette_color = f_color;

  // ---------------- assertions ----------------
  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    a_v[NA-1] |-> (a_seg[NA-1] < count_eff))
    else $error("segment not reduced below colour count");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    a_v[NA-1] |-> (a_rem[NA-1] < steps_eff))
    else $error("position not below step count");

  a_pct_in_range: assert property (@(posedge clk) disable iff (rst)
    c_v |-> (c_pct < gpl_pkg::PCT_SCALE))
    else $error("percent out of range");

  a_stall_holds_output: assert property (@(posedge clk) disable iff (rst)
    (f_v && !color_chan.ready) |=> (f_v && $stable(f_color) && $stable(e_v)))
    else $error("pipeline moved while output stalled");

endmodule

/* bench/gpl_checker.sv */
`timescale 1ns / 100ps
module gpl_checker
  import gpl_pkg::*;
#(
  parameter int MAX_COLORS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  gpl_index_if                  index_mon,
  gpl_color_if                  color_mon,
  output int                    failures,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    color_t           color;
  } lookup_t;

  lookup_t expected_colors[$];

  // shadow copy of the register file, updated from the write port
  logic [COUNT_W-1:0] num_colors_q;
  logic [STEPS_W-1:0] steps_q;
  color_t             key_q [KEY_SLOTS];

  function automatic color_t gradient_color(input logic [IDX_W-1:0] idx);
    int     count, steps, seg, pos, pct, nxt;
    int     a, b, delta;
    color_t ca, cb, res;
    count = int'(num_colors_q);
    steps = int'(steps_q);
    if (count == 0) count = 1;
    if (count > MAX_COLORS) count = MAX_COLORS;
    if (steps == 0) steps = 1;
    seg = (int'(idx) / steps) % count;
    pos = int'(idx) % steps;
    pct = (pos * 100) / steps;
    nxt = (seg + 1) % count;
    ca  = key_q[seg];
    cb  = key_q[nxt];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a     = int'(ca[CH_W*ch +: CH_W]);
      b     = int'(cb[CH_W*ch +: CH_W]);
      delta = b - a;
      // int division truncates toward zero, as needed for falling channels
      res[CH_W*ch +: CH_W] = CH_W'(a + (delta * pct) / 100);
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    lookup_t head;
    if (rst) begin
      num_colors_q = NUM_COLORS_RESET;
      steps_q      = STEPS_RESET;
      key_q        = KEY_RESET;
      expected_colors.delete();
      failures     = 0;
      checked      = 0;
    end else begin
      if (color_mon.valid && color_mon.ready) begin
        if (expected_colors.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: colour %06h with no request pending", $time,
                     color_mon.palette_color);
        end else begin
          head = expected_colors.pop_front();
          checked++;
          if (head.color !== color_mon.palette_color) begin
            failures++;
            if (failures <= 10)
              $display("%0t: index %0d colour expected %06h got %06h", $time,
                       head.idx, head.color, color_mon.palette_color);
          end
        end
      end
      if (index_mon.valid && index_mon.ready)
        expected_colors.push_back('{idx: index_mon.palette_index,
                                    color: gradient_color(index_mon.palette_index)});
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_COLORS:      num_colors_q = cfg_data[COUNT_W-1:0];
          REG_STEPS_PER_COLOR: steps_q      = cfg_data[STEPS_W-1:0];
          default:             key_q[int'(cfg_index) - KEY_BASE] = cfg_data[COLOR_W-1:0];
        endcase
      end
    end
    pending = expected_colors.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import gpl_pkg::*;

  localparam int MAX_COLORS   = 6;
  localparam int NUM_SETTINGS = 10;
  localparam int RAND_PER_SET = 55;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_ADDR_W-1:0] cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    failures;
  int                    pending;
  int                    checked;
  int                    src_mode;
  int                    src_count;

  gpl_index_if index_chan ();
  gpl_color_if color_chan ();

  gradient_palette_lookup #(
    .MAX_COLORS (MAX_COLORS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .index_chan (index_chan),
    .color_chan (color_chan)
  );

  gpl_checker #(
    .MAX_COLORS (MAX_COLORS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .index_mon (index_chan),
    .color_mon (color_chan),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[gradient_palette_lookup] ERROR");
    $finish;
  end

  // mode 0: no gaps, 1: occasional gaps, 2: gaps of 0..8 throughout
  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic color_t rand_key();
    color_t c;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(0, 3))
        0:       c[CH_W*ch +: CH_W] = '0;
        1:       c[CH_W*ch +: CH_W] = '1;
        default: c[CH_W*ch +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return c;
  endfunction

  // uniform indexes, plus a share aimed at segment boundaries
  function automatic logic [IDX_W-1:0] rand_index(input int eff_steps);
    int k, pos;
    if ($urandom_range(0, 3) != 0) return IDX_W'($urandom_range(0, 2047));
    k = $urandom_range(0, 2047 / eff_steps);
    case ($urandom_range(0, 2))
      0:       pos = 0;
      1:       pos = eff_steps - 1;
      default: pos = $urandom_range(0, eff_steps - 1);
    endcase
    return IDX_W'(k * eff_steps + pos);
  endfunction

  task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= addr;
    cfg_data  <= data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    if (src_count % 30 == 0) src_mode = $urandom_range(0, 2);
    src_count++;
    gap = draw_gap(src_mode);
    @(negedge clk);
    if (gap > 0) begin
      index_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    index_chan.valid         <= 1'b1;
    index_chan.palette_index <= idx;
    do @(posedge clk); while (!index_chan.ready);
  endtask

  // hold requests back until every colour is home
  task automatic wait_drained();
    @(negedge clk);
    index_chan.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap, sink_mode, n;
    color_chan.ready = 1'b0;
    sink_mode = 0;
    n = 0;
    forever begin
      if (n % 30 == 0) sink_mode = $urandom_range(0, 2);
      n++;
      gap = draw_gap(sink_mode);
      @(negedge clk);
      if (gap > 0) begin
        color_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      color_chan.ready <= 1'b1;
      do @(posedge clk); while (!color_chan.valid);
    end
  end

  initial begin : stimulus
    logic [COUNT_W-1:0] num;
    logic [STEPS_W-1:0] steps;
    key_reset_t         keys;
    int                 eff_cnt, eff_steps, n_sent;
    int                 first_idx [5];
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_data                 = '0;
    index_chan.valid         = 1'b0;
    index_chan.palette_index = '0;
    src_mode                 = 0;
    src_count                = 0;
    n_sent                   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p == 0) begin
        num   = NUM_COLORS_RESET;
        steps = STEPS_RESET;
        keys  = KEY_RESET;
      end else begin
        for (int k = 0; k < KEY_SLOTS; k++) keys[k] = rand_key();
        case (p)
          1: begin
            num   = 3'd6;
            steps = 8'd255;
            keys  = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF,
                      24'h123456, 24'hFEDCBA};
          end
          2: begin  // single key colour, one step
            num   = 3'd1;
            steps = 8'd1;
          end
          3: begin  // zero count and zero steps fall back to one
            num   = 3'd0;
            steps = 8'd0;
          end
          4: begin  // count above the maximum saturates
            num   = 3'd7;
            steps = 8'd7;
          end
          default: begin
            num   = COUNT_W'($urandom_range(0, 7));
            steps = ($urandom_range(0, 3) == 0) ? STEPS_W'($urandom_range(1, 10))
                                                : STEPS_W'($urandom_range(0, 255));
          end
        endcase
        wait_drained();
        write_reg(REG_NUM_COLORS, CFG_W'(num));
        write_reg(REG_STEPS_PER_COLOR, CFG_W'(steps));
        for (int k = 0; k < KEY_SLOTS; k++)
          write_reg(REG_ADDR_W'(KEY_BASE + k), keys[k]);
        end_writes();
      end

      eff_cnt   = (num == 0) ? 1 : ((int'(num) > MAX_COLORS) ? MAX_COLORS : int'(num));
      eff_steps = (steps == 0) ? 1 : int'(steps);

      if (p < 5) begin
        first_idx = '{0, eff_steps - 1, eff_cnt * eff_steps - 1, eff_cnt * eff_steps, 2047};
        for (int i = 0; i < 5; i++) begin
          send_index(IDX_W'(first_idx[i]));
          n_sent++;
        end
      end

      for (int i = 0; i < RAND_PER_SET; i++) begin
        if (p == 6 && i == RAND_PER_SET / 2) wait_drained();
        send_index(rand_index(eff_steps));
        n_sent++;
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);

    $display("Sent %0d palette lookups over %0d register settings, %0d colours compared,",
             n_sent, NUM_SETTINGS, checked);
    $display("with random gaps on both channels and a full drain before each setting.");
    if (failures == 0 && pending == 0) begin
      $display("[gradient_palette_lookup] OK");
    end else begin
      $display("[gradient_palette_lookup] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/gpl_pkg.sv
hdl/gpl_index_if.sv
hdl/gpl_color_if.sv
hdl/gradient_palette_lookup.sv
bench/gpl_checker.sv
bench/tb_top.sv
